[src/kgd_pkg.sv]
`timescale 1ns / 1ps
package kgd_pkg;

    localparam int KEYS   = 16;
    localparam int KEY_W  = 4;
    localparam int GRP_W  = 4;
    localparam int GROUPS = 16;
    localparam int CNT_W  = 16;
    localparam int DT_W   = 8;
    localparam int CODE_W = 3;

    typedef enum logic [2:0] {
        MODE_IDLE         = 3'd0,
        MODE_DEBOUNCE     = 3'd1,
        MODE_PRESSED      = 3'd2,
        MODE_LONG         = 3'd3,
        MODE_WAIT_RELEASE = 3'd4,
        MODE_WAIT_CLICK   = 3'd5
    } t_mode;

    typedef enum logic [CODE_W-1:0] {
        EV_DOWN   = 3'd0,
        EV_UP     = 3'd1,
        EV_CLICK  = 3'd2,
        EV_DOUBLE = 3'd3,
        EV_LONG   = 3'd4,
        EV_REPEAT = 3'd5,
        EV_COMBO  = 3'd6
    } t_event;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_LOAD,
        S_KEYS
    } t_phase;

    typedef enum logic [2:0] {
        REG_ENABLED  = 3'd0,
        REG_ACTIVE   = 3'd1,
        REG_GROUPS   = 3'd2,
        REG_EV_EN    = 3'd3,
        REG_DEBOUNCE = 3'd4,
        REG_CLICK    = 3'd5,
        REG_LONG     = 3'd6,
        REG_REPEAT   = 3'd7
    } t_reg;

    typedef struct packed {
        logic [CNT_W-1:0] settle_time;
        logic [CNT_W-1:0] click_window_ms;
        logic [CNT_W-1:0] long_time;
        logic [CNT_W-1:0] repeat_time;
    } t_times;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [DT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {{(CNT_W-DT_W+1){1'b0}}, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

endpackage

[src/kgd_lane.sv]
`timescale 1ns / 1ps
module kgd_lane (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic                       i_en,
    input  logic                       i_down,
    input  logic [kgd_pkg::DT_W-1:0]   i_dt,
    input  kgd_pkg::t_times            i_times,
    output logic                       o_held,
    output logic                       o_ev_valid,
    output kgd_pkg::t_event            o_ev_code
);
    import kgd_pkg::*;

    t_mode            r_mode, n_mode;
    logic [CNT_W-1:0] r_settle, n_settle, r_hold, n_hold;
    logic             r_long, n_long, r_second, n_second;
    logic             r_ev_valid, n_ev_valid;
    t_event           r_ev_code, n_ev_code;
    logic [CNT_W-1:0] settle_sum, hold_sum;

    always_comb begin
        settle_sum = sat_add(r_settle, i_dt);
        hold_sum   = sat_add(r_hold, i_dt);
        n_mode     = r_mode;
        n_settle   = r_settle;
        n_hold     = r_hold;
        n_long     = r_long;
        n_second   = r_second;
        n_ev_valid = 1'b0;
        n_ev_code  = EV_DOWN;
        if (!i_en) begin
            n_mode   = MODE_IDLE;
            n_settle = '0;
            n_hold   = '0;
            n_long   = 1'b0;
            n_second = 1'b0;
        end else begin
            unique case (r_mode)
                MODE_DEBOUNCE: begin
                    if (i_down) begin
                        n_settle = settle_sum;
                        if (settle_sum >= i_times.settle_time) begin
                            n_mode     = MODE_PRESSED;
                            n_hold     = '0;
                            n_long     = 1'b0;
                            n_ev_valid = 1'b1;
                            n_ev_code  = EV_DOWN;
                        end
                    end else begin
                        n_mode   = MODE_IDLE;
                        n_second = 1'b0;
                    end
                end
                MODE_PRESSED: begin
                    if (i_down) begin
                        n_hold = hold_sum;
                        if (hold_sum >= i_times.long_time) begin
                            n_ev_valid = 1'b1;
                            n_ev_code  = EV_LONG;
                            n_long     = 1'b1;
                            n_mode     = MODE_LONG;
                            n_hold     = '0;
                        end
                    end else begin
                        n_mode   = MODE_WAIT_RELEASE;
                        n_settle = '0;
                    end
                end
                MODE_LONG: begin
                    if (i_down) begin
                        n_hold = hold_sum;
                        if (hold_sum >= i_times.repeat_time) begin
                            n_hold     = '0;
                            n_ev_valid = 1'b1;
                            n_ev_code  = EV_REPEAT;
                        end
                    end else begin
                        n_mode   = MODE_WAIT_RELEASE;
                        n_settle = '0;
                    end
                end
                MODE_WAIT_RELEASE: begin
                    if (!i_down) begin
                        n_settle = settle_sum;
                        if (settle_sum >= i_times.settle_time) begin
                            n_ev_valid = 1'b1;
                            n_ev_code  = EV_UP;
                            if (r_long) begin
                                n_mode   = MODE_IDLE;
                                n_second = 1'b0;
                            end else begin
                                n_mode = MODE_WAIT_CLICK;
                                n_hold = '0;
                            end
                            n_long = 1'b0;
                        end
                    end else begin
                        n_mode   = MODE_DEBOUNCE;
                        n_settle = '0;
                    end
                end
                MODE_WAIT_CLICK: begin
                    n_hold = hold_sum;
                    if (i_down) begin
                        n_mode   = MODE_DEBOUNCE;
                        n_settle = '0;
                        n_second = 1'b1;
                    end else if (r_second) begin
                        n_ev_valid = 1'b1;
                        n_ev_code  = EV_DOUBLE;
                        n_mode     = MODE_IDLE;
                        n_second   = 1'b0;
                    end else if (hold_sum >= i_times.click_window_ms) begin
                        n_ev_valid = 1'b1;
                        n_ev_code  = EV_CLICK;
                        n_mode     = MODE_IDLE;
                        n_second   = 1'b0;
                    end
                end
                default: begin
                    n_mode   = MODE_IDLE;
                    n_second = 1'b0;
                    if (i_down) begin
                        n_mode   = MODE_DEBOUNCE;
                        n_settle = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_settle   <= '0;
            r_hold     <= '0;
            r_long     <= 1'b0;
            r_second   <= 1'b0;
            r_ev_valid <= 1'b0;
            r_ev_code  <= EV_DOWN;
        end else if (i_step) begin
            r_mode     <= n_mode;
            r_settle   <= n_settle;
            r_hold     <= n_hold;
            r_long     <= n_long;
            r_second   <= n_second;
            r_ev_valid <= n_ev_valid;
            r_ev_code  <= n_ev_code;
        end
    end

    assign o_held     = i_en && (r_mode == MODE_PRESSED || r_mode == MODE_LONG);
    assign o_ev_valid = r_ev_valid;
    assign o_ev_code  = r_ev_code;

endmodule

[src/kgd_merge.sv]
`timescale 1ns / 1ps
module kgd_merge (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic                                  i_ev_enable,
    input  logic [kgd_pkg::KEYS-1:0]              i_enabled,
    input  logic [kgd_pkg::KEYS*kgd_pkg::GRP_W-1:0] i_group_map,
    input  logic [kgd_pkg::KEYS-1:0]              i_held,
    input  logic [kgd_pkg::KEYS-1:0]              i_ev_valid,
    input  kgd_pkg::t_event [kgd_pkg::KEYS-1:0]   i_ev_code,
    input  logic                                  i_out_ready,
    output logic                                  o_idle,
    output logic                                  o_step,
    output logic                                  o_out_valid,
    output logic [kgd_pkg::KEY_W-1:0]             o_out_key,
    output kgd_pkg::t_event                       o_out_code,
    output logic                                  o_out_last
);
    import kgd_pkg::*;

    t_phase            r_phase, n_phase;
    logic              r_combo, n_combo;
    logic              r_grp_load, n_grp_load;
    logic [GRP_W-1:0]  r_grp, n_grp;
    logic [KEYS-1:0]   r_pend, n_pend;
    logic              r_vld, n_vld;
    logic [KEY_W-1:0]  r_key, n_key;
    t_event            r_code, n_code;
    logic              r_last, n_last;

    logic [GROUPS-1:0] act;
    logic [KEYS-1:0]   cmask, rest;
    logic [KEY_W-1:0]  pick;
    logic              later, fire;

    always_comb begin
        act = '0;
        for (int g = 1; g < GROUPS; g++) begin
            logic [KEYS-1:0] mem;
            mem = '0;
            for (int k = 0; k < KEYS; k++) begin
                mem[k] = i_enabled[k] && (i_group_map[k*GRP_W +: GRP_W] == GRP_W'(g));
            end
            act[g] = (mem != '0) && ((mem & ~i_held) == '0);
        end
        cmask = '0;
        for (int k = 0; k < KEYS; k++) begin
            cmask[k] = i_enabled[k] && (i_group_map[k*GRP_W +: GRP_W] == r_grp);
        end
        pick = '0;
        for (int k = KEYS - 1; k >= 0; k--) begin
            if (r_pend[k]) begin
                pick = KEY_W'(k);
            end
        end
        later = 1'b0;
        for (int g = 1; g < GROUPS; g++) begin
            if (!r_combo || GRP_W'(g) > r_grp) begin
                later = later | act[g];
            end
        end
        rest = r_pend & ~(KEYS'(1) << pick);
    end

    always_comb begin
        n_phase    = r_phase;
        n_combo    = r_combo;
        n_grp_load = r_grp_load;
        n_grp      = r_grp;
        n_pend     = r_pend;
        n_vld      = r_vld && !i_out_ready;
        n_key      = r_key;
        n_code     = r_code;
        n_last     = r_last;
        fire       = 1'b0;
        unique case (r_phase)
            S_IDLE: begin
                if (i_start) begin
                    n_phase = S_STEP;
                end
            end
            S_STEP: begin
                n_phase = S_LOAD;
            end
            S_LOAD: begin
                n_pend     = i_ev_valid;
                n_combo    = 1'b0;
                n_grp_load = 1'b0;
                n_grp      = GRP_W'(1);
                n_phase    = i_ev_enable ? S_KEYS : S_IDLE;
            end
            S_KEYS: begin
                if (r_grp_load) begin
                    n_pend     = act[r_grp] ? cmask : '0;
                    n_grp_load = 1'b0;
                end else if (r_pend != '0) begin
                    if (!r_vld || i_out_ready) begin
                        fire   = 1'b1;
                        n_vld  = 1'b1;
                        n_key  = pick;
                        n_code = r_combo ? EV_COMBO : i_ev_code[pick];
                        n_last = (rest == '0) && !later;
                        n_pend = rest;
                        if ((rest == '0) && !later) begin
                            n_phase = S_IDLE;
                        end
                    end
                end else if (!later) begin
                    n_phase = S_IDLE;
                end else if (!r_combo) begin
                    n_combo    = 1'b1;
                    n_grp_load = 1'b1;
                end else begin
                    n_grp      = r_grp + GRP_W'(1);
                    n_grp_load = 1'b1;
                end
            end
            default: n_phase = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= S_IDLE;
            r_combo    <= 1'b0;
            r_grp_load <= 1'b0;
            r_grp      <= '0;
            r_pend     <= '0;
            r_vld      <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_combo    <= n_combo;
            r_grp_load <= n_grp_load;
            r_grp      <= n_grp;
            r_pend     <= n_pend;
            r_vld      <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_key  <= n_key;
            r_code <= n_code;
            r_last <= n_last;
        end
    end

    assign o_idle      = (r_phase == S_IDLE);
    assign o_step      = (r_phase == S_STEP);
    assign o_out_valid = r_vld;
    assign o_out_key   = r_key;
    assign o_out_code  = r_code;
    assign o_out_last  = r_last;

endmodule

[src/key_gesture_detector_top.sv]
`timescale 1ns / 1ps
// Channel  Direction  Contents
// s_axis   in         tick: key levels and elapsed milliseconds
// m_axis   out        event: key index, event code, tlast on final event of tick
// apb      in/out     configuration registers at byte address 8*i
//
// A tick steps all 16 key lanes together in S_STEP, then S_LOAD takes their
// events and the merge unit walks keys and combo groups in S_KEYS, one event
// per cycle while m_axis_tready holds; the lanes step on a single-cycle strobe.
// A new tick is taken once the walk ends, while the last event may still wait.
// Reset is synchronous: keys idle, registers at their defaults.
module key_gesture_detector_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // key_levels[15:0], elapsed_ms[23:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // key_index[3:0], event_code[6:4], zero[7]
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import kgd_pkg::*;

    logic [KEYS-1:0]       r_enabled, r_active;
    logic [KEYS*GRP_W-1:0] r_groups;
    logic                  r_ev_en;
    t_times                r_times;
    logic [KEYS-1:0]       r_levels;
    logic [DT_W-1:0]       r_dt;
    logic [KEYS-1:0]       held, ev_valid;
    t_event [KEYS-1:0]     ev_code;
    logic                  idle, step, accept, wr;
    logic [KEY_W-1:0]      out_key;
    t_event                out_code;
    t_reg                  sel;

    assign pready        = 1'b1;
    assign sel           = t_reg'(paddr[5:3]);
    assign wr            = psel && penable && pwrite && pready;
    assign s_axis_tready = idle;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled               <= '0;
            r_active                <= '0;
            r_groups                <= '0;
            r_ev_en                 <= 1'b1;
            r_times.settle_time     <= CNT_W'(20);
            r_times.click_window_ms <= CNT_W'(250);
            r_times.long_time       <= CNT_W'(1000);
            r_times.repeat_time     <= CNT_W'(200);
        end else if (wr) begin
            unique case (sel)
                REG_ENABLED:  r_enabled               <= pwdata[KEYS-1:0];
                REG_ACTIVE:   r_active                <= pwdata[KEYS-1:0];
                REG_GROUPS:   r_groups                <= pwdata[KEYS*GRP_W-1:0];
                REG_EV_EN:    r_ev_en                 <= pwdata[0];
                REG_DEBOUNCE: r_times.settle_time     <= pwdata[CNT_W-1:0];
                REG_CLICK:    r_times.click_window_ms <= pwdata[CNT_W-1:0];
                REG_LONG:     r_times.long_time       <= pwdata[CNT_W-1:0];
                REG_REPEAT:   r_times.repeat_time     <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (sel)
            REG_ENABLED:  prdata[KEYS-1:0]       = r_enabled;
            REG_ACTIVE:   prdata[KEYS-1:0]       = r_active;
            REG_GROUPS:   prdata[KEYS*GRP_W-1:0] = r_groups;
            REG_EV_EN:    prdata[0]              = r_ev_en;
            REG_DEBOUNCE: prdata[CNT_W-1:0]      = r_times.settle_time;
            REG_CLICK:    prdata[CNT_W-1:0]      = r_times.click_window_ms;
            REG_LONG:     prdata[CNT_W-1:0]      = r_times.long_time;
            REG_REPEAT:   prdata[CNT_W-1:0]      = r_times.repeat_time;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_levels <= s_axis_tdata[KEYS-1:0];
            r_dt     <= s_axis_tdata[23:16];
        end
    end

    for (genvar k = 0; k < KEYS; k++) begin : g_lane
        kgd_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_step     (step),
            .i_en       (r_enabled[k]),
            .i_down     (r_levels[k] == r_active[k]),
            .i_dt       (r_dt),
            .i_times    (r_times),
            .o_held     (held[k]),
            .o_ev_valid (ev_valid[k]),
            .o_ev_code  (ev_code[k])
        );
    end

    kgd_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (accept),
        .i_ev_enable (r_ev_en),
        .i_enabled   (r_enabled),
        .i_group_map (r_groups),
        .i_held      (held),
        .i_ev_valid  (ev_valid),
        .i_ev_code   (ev_code),
        .i_out_ready (m_axis_tready),
        .o_idle      (idle),
        .o_step      (step),
        .o_out_valid (m_axis_tvalid),
        .o_out_key   (out_key),
        .o_out_code  (out_code),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_code, out_key};

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> step)
        else $error("lanes did not step after tick transaction");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |-> !s_axis_tready)
        else $error("tick taken while lanes step");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:4] != 4'd7 && m_axis_tdata[7] == 1'b0))
        else $error("invalid event code");

endmodule
